[hdl/kgsa_pkg.sv]
package kgsa_pkg;

    localparam int GRP_W          = 7;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int NUM_GROUPS_DEF = 128;

    localparam logic [CFG_W-1:0] LAST_TRANSIENT_RST  = CFG_W'(63);
    localparam logic [CFG_W-1:0] LAST_PERSISTENT_RST = CFG_W'(127);

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_TRANSIENT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PERSISTENT = 1'b1;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [GRP_W-1:0] group;
        logic             want_persistent;
        logic             full_flag;
    } req_t;

    typedef struct packed {
        logic [GRP_W-1:0] found_group;
        logic             status;
    } rsp_t;

endpackage

[hdl/key_group_slot_allocator_top.sv]
// A get reads its start group when taken and then examines table entries in ST_SCAN, at most
// NUM_GROUPS of them, up to its search limit; a set reads its group and answers from ST_SET,
// and a request that fails on its group or limit alone is answered straight from idle.
// Throughput: one request at a time; the scan reads one entry per cycle from the table RAM.
// The result strobe lasts one cycle, cannot be stalled, and start may be taken in that cycle.
// Reset: a clearing pass over all NUM_GROUPS entries with busy high; config writes are taken.
module key_group_slot_allocator_top #(
    parameter int NUM_GROUPS = kgsa_pkg::NUM_GROUPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  kgsa_pkg::req_t                 req,
    output logic                           done,
    output kgsa_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [kgsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kgsa_pkg::CFG_W-1:0]     cfg_wdata
);
    import kgsa_pkg::*;

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int WW = ((GW > GRP_W) ? GW : GRP_W) + 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_SET} state_t;

    typedef struct packed {
        logic valid;
        logic persistent;
        logic full;
    } entry_t;

    state_t            state_reg, state_next;
    logic [GW-1:0]     clr_addr_reg, clr_addr_next;
    logic [GW-1:0]     chk_addr_reg;
    logic [GW-1:0]     limit_reg, limit_next;
    req_t              req_reg, req_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;
    logic [CFG_W-1:0]  last_trans_reg, last_trans_next;
    logic [CFG_W-1:0]  last_pers_reg, last_pers_next;

    entry_t            mem [NUM_GROUPS];
    entry_t            rd_data_reg;
    logic [GW-1:0]     rd_addr;
    logic              mem_we;
    logic [GW-1:0]     mem_waddr;
    entry_t            mem_wdata;

    logic [CFG_W-1:0]  lim_raw;
    logic [GW-1:0]     lim_clamp;
    logic [WW-1:0]     grp_ext;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign lim_raw   = req.want_persistent ? last_pers_reg : last_trans_reg;
    assign lim_clamp = (WW'(lim_raw) > WW'(NUM_GROUPS - 1)) ? GW'(NUM_GROUPS - 1) : GW'(lim_raw);
    assign grp_ext   = WW'(req.group);

    // Issue the next read: start group on a request, next entry while scanning.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  rd_addr = GW'(req.group);
            ST_SCAN:  rd_addr = chk_addr_reg + GW'(1);
            default:  rd_addr = chk_addr_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        limit_next      = limit_reg;
        req_next        = req_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        last_trans_next = last_trans_reg;
        last_pers_next  = last_pers_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_addr_reg;
        mem_wdata       = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAST_TRANSIENT:  last_trans_next = cfg_wdata;
                CFG_LAST_PERSISTENT: last_pers_next  = cfg_wdata;
                default:             ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + GW'(1);
                if (clr_addr_reg == GW'(NUM_GROUPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    limit_next = lim_clamp;
                    if (req.mode == MODE_GET)
                    begin
                        if (grp_ext > WW'(lim_clamp))
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{found_group: req.group, status: STATUS_FAIL};
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (grp_ext >= WW'(NUM_GROUPS))
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{found_group: req.group, status: STATUS_FAIL};
                    end
                    else
                    begin
                        state_next = ST_SET;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!rd_data_reg.valid)
                begin
                    // Claim the unused group for this persistence class.
                    mem_we     = 1'b1;
                    mem_wdata  = '{valid: 1'b1, persistent: req_reg.want_persistent,
                                   full: 1'b0};
                    done_next  = 1'b1;
                    rsp_next   = '{found_group: GRP_W'(chk_addr_reg), status: STATUS_OK};
                    state_next = ST_IDLE;
                end
                else if (rd_data_reg.persistent == req_reg.want_persistent &&
                         !rd_data_reg.full)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{found_group: GRP_W'(chk_addr_reg), status: STATUS_OK};
                    state_next = ST_IDLE;
                end
                else if (chk_addr_reg == limit_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{found_group: req_reg.group, status: STATUS_FAIL};
                    state_next = ST_IDLE;
                end
            end
            ST_SET:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (!rd_data_reg.valid ||
                    rd_data_reg.persistent == req_reg.want_persistent)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{valid: 1'b1, persistent: req_reg.want_persistent,
                                  full: req_reg.full_flag};
                    rsp_next  = '{found_group: req_reg.group, status: STATUS_OK};
                end
                else
                begin
                    rsp_next  = '{found_group: req_reg.group, status: STATUS_FAIL};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            chk_addr_reg   <= '0;
            limit_reg      <= '0;
            req_reg        <= '0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
            last_trans_reg <= LAST_TRANSIENT_RST;
            last_pers_reg  <= LAST_PERSISTENT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            chk_addr_reg   <= rd_addr;
            limit_reg      <= limit_next;
            req_reg        <= req_next;
            done_reg       <= done_next;
            rsp_reg        <= rsp_next;
            last_trans_reg <= last_trans_next;
            last_pers_reg  <= last_pers_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done_reg)
        else $error("accepted request neither started nor answered");

    a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> chk_addr_reg <= limit_reg)
        else $error("scan address past its limit");

    a_write_means_success: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg != ST_CLEAR |=> done_reg && rsp_reg.status == STATUS_OK)
        else $error("table written without a successful result");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !done_reg)
        else $error("result strobe during clearing pass");

endmodule

[verif/tb_top.sv]
module tb_top;
    import kgsa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES  = 5;

    localparam int PH_TRANS [NUM_PHASES] = '{0, 127, 127, -1, 63};
    localparam int PH_PERS  [NUM_PHASES] = '{127, 0, 127, -1, 127};
    localparam int PH_IDLE  [NUM_PHASES] = '{0, 88, 0, 37, 88};
    localparam int PH_COUNT [NUM_PHASES] = '{300, 300, 400, 400, 430};

    typedef struct packed {
        logic             mode;
        logic [GRP_W-1:0] group;
        logic             want_persistent;
        logic             full_flag;
        bit               pinned;
        logic [GRP_W-1:0] exp_group;
        logic             exp_status;
    } probe_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // typed-in expectation that travels with the request
    logic                 pin_on;
    rsp_t                 pin_rsp;

    // shadow of the group table and the search limits
    bit                   tbl_valid [NUM_GROUPS_DEF];
    bit                   tbl_pers  [NUM_GROUPS_DEF];
    bit                   tbl_full  [NUM_GROUPS_DEF];
    logic [CFG_W-1:0]     lim_trans;
    logic [CFG_W-1:0]     lim_pers;

    rsp_t                 owed_rsp [$];
    int unsigned          mismatch_count;
    int unsigned          cycle_count;
    probe_t               plan [$];

    key_group_slot_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count, owed_rsp.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // first-fit search for get, claim or full-mark update for set; updates the shadow table
    function automatic rsp_t predict_alloc(input req_t r);
        rsp_t        o;
        int unsigned lim;
        int unsigned g;
        o.found_group = r.group;
        o.status      = STATUS_FAIL;
        if (r.mode == MODE_GET)
        begin
            lim = 32'(r.want_persistent ? lim_pers : lim_trans);
            if (lim > NUM_GROUPS_DEF - 1)
                lim = NUM_GROUPS_DEF - 1;
            for (g = 32'(r.group); g <= lim; g++)
            begin
                if (!tbl_valid[g])
                begin
                    tbl_valid[g]  = 1'b1;
                    tbl_pers[g]   = r.want_persistent;
                    tbl_full[g]   = 1'b0;
                    o.found_group = GRP_W'(g);
                    o.status      = STATUS_OK;
                    break;
                end
                if (tbl_pers[g] == r.want_persistent && !tbl_full[g])
                begin
                    o.found_group = GRP_W'(g);
                    o.status      = STATUS_OK;
                    break;
                end
            end
        end
        else if (r.group < NUM_GROUPS_DEF)
        begin
            if (!tbl_valid[r.group])
            begin
                tbl_valid[r.group] = 1'b1;
                tbl_pers[r.group]  = r.want_persistent;
                tbl_full[r.group]  = r.full_flag;
                o.status           = STATUS_OK;
            end
            else if (tbl_pers[r.group] == r.want_persistent)
            begin
                tbl_full[r.group] = r.full_flag;
                o.status          = STATUS_OK;
            end
        end
        return o;
    endfunction

    // check results first, then log the request taken at this edge
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (owed_rsp.size() == 0)
                    flag_mismatch($sformatf("unrequested result group %0d status %0b",
                                            rsp.found_group, rsp.status));
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.found_group !== want.found_group)
                        flag_mismatch($sformatf("found_group %0d, want %0d",
                                                rsp.found_group, want.found_group));
                    if (rsp.status !== want.status)
                        flag_mismatch($sformatf("status %0b, want %0b (group %0d)",
                                                rsp.status, want.status, want.found_group));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                want = predict_alloc(req);
                if (pin_on)
                    want = pin_rsp;
                owed_rsp.push_back(want);
            end
            if (cfg_we === 1'b1)
            begin
                if (cfg_index == CFG_LAST_TRANSIENT)
                    lim_trans = cfg_wdata;
                else
                    lim_pers = cfg_wdata;
            end
        end
    end

    function automatic probe_t probe(input logic m, input int g, input logic p, input logic f,
                                     input int pin, input int eg, input logic es);
        probe_t t;
        t.mode            = m;
        t.group           = GRP_W'(g);
        t.want_persistent = p;
        t.full_flag       = f;
        t.pinned          = (pin != 0);
        t.exp_group       = GRP_W'(eg);
        t.exp_status      = es;
        return t;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int unsigned lim;
        r.mode            = ($urandom_range(99) < 40) ? MODE_SET : MODE_GET;
        r.want_persistent = 1'($urandom_range(1));
        r.full_flag       = (r.mode == MODE_SET) ? ($urandom_range(4) < 3)
                                                 : 1'($urandom_range(1));
        lim               = 32'(r.want_persistent ? lim_pers : lim_trans);
        case ($urandom_range(3))
            0: r.group = GRP_W'($urandom_range(127));
            1: r.group = GRP_W'($urandom_range(15));
            2: r.group = GRP_W'($urandom_range(127, 112));
            default:
            begin
                // land near the search limit, on both sides of it
                lim = lim + $urandom_range(4);
                lim = (lim < 2) ? 0 : lim - 2;
                r.group = (lim > 127) ? GRP_W'(127) : GRP_W'(lim);
            end
        endcase
        return r;
    endfunction

    task automatic issue(input req_t r, input bit pinned, input rsp_t want, input int idle_pct);
        req     <= r;
        pin_on  <= pinned;
        pin_rsp <= want;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    // hold off new requests until every owed result is back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed_rsp.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_limits(input logic [CFG_W-1:0] trans_lim,
                                input logic [CFG_W-1:0] pers_lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LAST_TRANSIENT;
        cfg_wdata <= trans_lim;
        @(posedge clk);
        cfg_index <= CFG_LAST_PERSISTENT;
        cfg_wdata <= pers_lim;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        req_t r;
        rsp_t w;
        int   tl;
        int   pl;
        bit   burst;

        start          = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        pin_on         = 1'b0;
        pin_rsp        = '0;
        lim_trans      = LAST_TRANSIENT_RST;
        lim_pers       = LAST_PERSISTENT_RST;
        mismatch_count = 0;
        cycle_count    = 0;
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_pers[i]  = 1'b0;
            tbl_full[i]  = 1'b0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // table clearing pass runs with busy high
        do
            @(posedge clk);
        while (busy !== 1'b0);

        // reset limits: transient 63, persistent 127
        plan.push_back(probe(MODE_GET, 0,   1'b0, 1'b0, 1, 0,   STATUS_OK));
        plan.push_back(probe(MODE_GET, 0,   1'b0, 1'b0, 1, 0,   STATUS_OK));
        plan.push_back(probe(MODE_SET, 0,   1'b0, 1'b1, 1, 0,   STATUS_OK));
        plan.push_back(probe(MODE_GET, 0,   1'b0, 1'b0, 1, 1,   STATUS_OK));
        plan.push_back(probe(MODE_SET, 1,   1'b1, 1'b0, 1, 1,   STATUS_FAIL));
        plan.push_back(probe(MODE_GET, 0,   1'b1, 1'b0, 0, 0,   STATUS_OK));
        plan.push_back(probe(MODE_GET, 64,  1'b0, 1'b0, 1, 64,  STATUS_FAIL));
        plan.push_back(probe(MODE_GET, 127, 1'b1, 1'b0, 1, 127, STATUS_OK));
        plan.push_back(probe(MODE_SET, 127, 1'b1, 1'b1, 1, 127, STATUS_OK));
        plan.push_back(probe(MODE_GET, 127, 1'b1, 1'b0, 1, 127, STATUS_FAIL));
        plan.push_back(probe(MODE_GET, 63,  1'b0, 1'b0, 1, 63,  STATUS_OK));
        plan.push_back(probe(MODE_SET, 126, 1'b0, 1'b1, 1, 126, STATUS_OK));
        plan.push_back(probe(MODE_GET, 126, 1'b1, 1'b0, 1, 126, STATUS_FAIL));
        plan.push_back(probe(MODE_GET, 0,   1'b0, 1'b1, 0, 0,   STATUS_OK));
        plan.push_back(probe(MODE_SET, 2,   1'b1, 1'b1, 1, 2,   STATUS_OK));
        plan.push_back(probe(MODE_SET, 127, 1'b1, 1'b0, 1, 127, STATUS_OK));
        plan.push_back(probe(MODE_GET, 126, 1'b1, 1'b1, 0, 0,   STATUS_OK));

        foreach (plan[i])
        begin
            r.mode            = plan[i].mode;
            r.group           = plan[i].group;
            r.want_persistent = plan[i].want_persistent;
            r.full_flag       = plan[i].full_flag;
            w.found_group     = plan[i].exp_group;
            w.status          = plan[i].exp_status;
            issue(r, plan[i].pinned, w, 0);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            tl = (PH_TRANS[ph] < 0) ? $urandom_range(127) : PH_TRANS[ph];
            pl = (PH_PERS[ph] < 0) ? $urandom_range(127) : PH_PERS[ph];
            write_limits(CFG_W'(tl), CFG_W'(pl));
            burst = 1'b0;
            for (int n = 0; n < PH_COUNT[ph]; n++)
            begin
                // occasional back-to-back stretch inside idling phases
                if (n % 64 == 0)
                    burst = ($urandom_range(3) == 0);
                if ($urandom_range(199) == 0)
                    drain();
                issue(random_req(), 1'b0, '0, burst ? 0 : PH_IDLE[ph]);
            end
        end

        drain();
        repeat (140) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
